FILE: sv/alec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alec_pkg
// Shared types and codes for the array list engine: transaction payloads,
// operation codes, status codes and the default list capacity.
// ----------------------------------------------------------------------------
package alec_pkg;

    // Default number of list entries
    localparam int CAPACITY = 8;

    // Width of the rotate step count
    localparam int STEP_W = 16;

    // Operation codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_ROTATE = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Operation transaction
    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         position;
        logic signed [31:0] value;
        logic [STEP_W-1:0]  rotate_steps;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         found_index;
        logic signed [31:0] item_value;
        logic [3:0]         entry_count;
        logic               last;
    } t_out_item;

endpackage

FILE: sv/array_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_core
// Fixed-capacity ordered list of signed 32-bit values: insert, delete,
// search, rotate right and read-out, executed as walks over list memory.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                  payload
//  in        in    i_in_valid / o_in_ready    i_in_item  (alec_pkg::t_in_item)
//  out       out   o_out_valid / i_out_ready  o_out_item (alec_pkg::t_out_item)
//
//  One operation at a time; o_in_ready is high only when the sequencer idles.
//  Insert shifts entries up from the tail, delete shifts them down, search
//  and read-out walk from the head, and rotate forms a bit-serial remainder,
//  then makes one copy pass into the spare bank.
//  All walks go through the one read port of the list memory.
//  Reset (synchronous, active low) empties the list; no clearing pass.
//  A held result in the output register stalls only read-out and responses.
// ----------------------------------------------------------------------------
module array_list_engine_core #(
    parameter int CAPACITY = alec_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  alec_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alec_pkg::t_out_item o_out_item
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS     = 4'd1;
    localparam logic [3:0] S_INS_PUT = 4'd2;
    localparam logic [3:0] S_DEL     = 4'd3;
    localparam logic [3:0] S_SRCH    = 4'd4;
    localparam logic [3:0] S_MOD     = 4'd5;
    localparam logic [3:0] S_ROT     = 4'd6;
    localparam logic [3:0] S_RDO     = 4'd7;
    localparam logic [3:0] S_RESP    = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_dst, n_dst;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_found, n_found;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_bank, n_bank;
    logic [31:0]   r_val, n_val;
    logic [2:0]    r_status, n_status;

    logic                r_out_vld;
    alec_pkg::t_out_item r_out;

    logic                w_emit;
    alec_pkg::t_out_item w_emit_item;
    logic                w_free;

    logic [31:0]   w_q0, w_q1, w_q;
    logic          w_we;
    logic          w_wbank;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_wdata;

    logic          w_mod_start;
    logic          w_mod_done;
    logic [CW-1:0] w_mod_rem;

    logic [CW+3:0] w_pos_ext;
    logic [CW+3:0] w_cnt_ext;
    logic [IW-1:0] w_pos_idx;
    logic [CW-1:0] w_cnt_m1;
    logic [IW-1:0] w_last_idx;
    logic          w_full;
    logic          w_empty;
    logic [CW+3:0] w_cnt_out;
    logic [IW+2:0] w_found_out;

    // Operand compares and conversions
    always_comb begin
        w_pos_ext   = {{CW{1'b0}}, i_in_item.position};
        w_cnt_ext   = {4'b0000, r_cnt};
        w_pos_idx   = w_pos_ext[IW-1:0];
        w_cnt_m1    = r_cnt - CW'(1);
        w_last_idx  = w_cnt_m1[IW-1:0];
        w_full      = (r_cnt >= CW'(CAPACITY));
        w_empty     = (r_cnt == '0);
        w_cnt_out   = {4'b0000, r_cnt};
        w_found_out = {3'b000, r_found};
        w_q         = r_bank ? w_q1 : w_q0;
        w_free      = !r_out_vld || i_out_ready;
    end

    // Sequencer: decode the operation, then walk the list
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_dst       = r_dst;
        n_pos       = r_pos;
        n_found     = r_found;
        n_cnt       = r_cnt;
        n_bank      = r_bank;
        n_val       = r_val;
        n_status    = r_status;
        w_mod_start = 1'b0;
        w_emit      = 1'b0;
        w_emit_item = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos    = w_pos_idx;
                    n_val    = i_in_item.value;
                    n_found  = '0;
                    n_status = alec_pkg::ST_OK;
                    n_state  = S_RESP;
                    unique case (i_in_item.action)
                        alec_pkg::ACT_INSERT: begin
                            if (w_full) begin
                                n_status = alec_pkg::ST_FULL;
                            end else if (w_pos_ext > w_cnt_ext) begin
                                n_status = alec_pkg::ST_BADPOS;
                            end else if (w_pos_ext == w_cnt_ext) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_idx   = w_last_idx;
                                n_state = S_INS;
                            end
                        end
                        alec_pkg::ACT_DELETE: begin
                            if (w_empty) begin
                                n_status = alec_pkg::ST_EMPTY;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_status = alec_pkg::ST_BADPOS;
                            end else if (w_pos_idx == w_last_idx) begin
                                n_cnt = w_cnt_m1;
                            end else begin
                                n_idx   = w_pos_idx + IW'(1);
                                n_state = S_DEL;
                            end
                        end
                        alec_pkg::ACT_SEARCH: begin
                            if (w_empty) begin
                                n_status = alec_pkg::ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SRCH;
                            end
                        end
                        alec_pkg::ACT_ROTATE: begin
                            if (w_empty) begin
                                n_status = alec_pkg::ST_EMPTY;
                            end else begin
                                n_idx       = '0;
                                w_mod_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                        alec_pkg::ACT_READ: begin
                            if (w_empty) begin
                                n_status = alec_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_RDO;
                            end
                        end
                        default: begin
                            n_status = alec_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_idx == r_pos) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            S_INS_PUT: begin
                n_cnt   = r_cnt + CW'(1);
                n_state = S_RESP;
            end
            S_DEL: begin
                if (r_idx == w_last_idx) begin
                    n_cnt   = w_cnt_m1;
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_SRCH: begin
                if (w_q == r_val) begin
                    n_found = r_idx;
                    n_state = S_RESP;
                end else if (r_idx == w_last_idx) begin
                    n_status = alec_pkg::ST_NOTFOUND;
                    n_state  = S_RESP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_dst   = w_mod_rem[IW-1:0];
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                n_dst = (r_dst == w_last_idx) ? '0 : (r_dst + IW'(1));
                if (r_idx == w_last_idx) begin
                    n_bank  = !r_bank;
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_RDO: begin
                if (w_free) begin
                    w_emit                  = 1'b1;
                    w_emit_item.status      = alec_pkg::ST_OK;
                    w_emit_item.item_value  = w_q;
                    w_emit_item.entry_count = w_cnt_out[3:0];
                    w_emit_item.last        = (r_idx == w_last_idx);
                    if (r_idx == w_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_RESP: begin
                if (w_free) begin
                    w_emit                  = 1'b1;
                    w_emit_item.status      = r_status;
                    w_emit_item.found_index = w_found_out[2:0];
                    w_emit_item.entry_count = w_cnt_out[3:0];
                    w_emit_item.last        = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory write: shift up, place value, shift down, copy to spare bank
    always_comb begin
        w_we    = 1'b0;
        w_wbank = r_bank;
        w_waddr = r_idx;
        w_wdata = w_q;
        unique case (r_state)
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_idx + IW'(1);
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = r_val;
            end
            S_DEL: begin
                w_we    = 1'b1;
                w_waddr = r_idx - IW'(1);
            end
            S_ROT: begin
                w_we    = 1'b1;
                w_wbank = !r_bank;
                w_waddr = r_dst;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_bank    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold working registers and the output payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_dst    <= n_dst;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_val    <= n_val;
        r_status <= n_status;
        if (w_emit) begin
            r_out <= w_emit_item;
        end
    end

    // List banks; a rotate copies into the spare bank and swaps
    alec_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we && !w_wbank),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_q0)
    );

    alec_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we && w_wbank),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_q1)
    );

    // Step count reduction for rotate
    alec_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_in_item.rotate_steps),
        .i_divisor  (r_cnt),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // Count never exceeds capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Count moves by at most one per cycle
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + CW'(1))
        || (r_cnt + CW'(1) == $past(r_cnt)))
        else $error("entry count jumped");

    // Bank swaps only at the end of a rotate copy
    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> ($past(r_state) == S_ROT))
        else $error("bank swapped outside rotate");

    // Shift-up walk stays inside a list with room
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> ((r_cnt < CW'(CAPACITY)) && (r_idx >= r_pos)))
        else $error("insert walk out of range");
`endif

endmodule

FILE: sv/alec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alec_ram
// Generic single-write, single-read synchronous RAM with registered read
// data (read-before-write on an address collision).
// ----------------------------------------------------------------------------
module alec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/alec_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alec_mod
// Iterative remainder unit: reduces the rotate step count modulo the entry
// count, one dividend bit per cycle (restoring scheme).
// ----------------------------------------------------------------------------
module alec_mod #(
    parameter int CW = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [alec_pkg::STEP_W-1:0] i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [CW-1:0]              o_rem
);

    localparam int BW = $clog2(alec_pkg::STEP_W);

    logic                        r_busy;
    logic                        r_done;
    logic [BW-1:0]               r_bit;
    logic [alec_pkg::STEP_W-1:0] r_num;
    logic [CW-1:0]               r_div;
    logic [CW-1:0]               r_rem;

    logic [CW:0] w_trial;
    logic        w_ge;
    logic [CW:0] w_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_num[r_bit]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_next  = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
    end

    // Control: start, count down bits, flag done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_bit == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_bit == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: latch operands, iterate the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_bit <= BW'(alec_pkg::STEP_W - 1);
        end else if (r_busy) begin
            r_rem <= w_next[CW-1:0];
            r_bit <= r_bit - BW'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    // Remainder must be below the divisor when reported
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
`endif

endmodule
